### rtl/core/mlr_pkg.sv
// ----------------------------------------------------------------------------
// mlr_pkg
// Shared types and constants of the midpoint line rasterizer.
// ----------------------------------------------------------------------------
package mlr_pkg;

    localparam int COORD_BITS_DEF = 11;

    // item kinds on the command channel
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } t_op;

    // octant codes: X/Y is the major axis, then sign of dx and of dy (P >= 0, N < 0)
    typedef enum logic [2:0] {
        OCT_X_PP = 3'd0,
        OCT_Y_PP = 3'd1,
        OCT_Y_NP = 3'd2,
        OCT_X_NP = 3'd3,
        OCT_X_NN = 3'd4,
        OCT_Y_NN = 3'd5,
        OCT_Y_PN = 3'd6,
        OCT_X_PN = 3'd7
    } t_octant;

endpackage

### rtl/core/mlr_cmd_if.sv
// ----------------------------------------------------------------------------
// mlr_cmd_if
// Command channel: load a line from two endpoints or request the next pixel.
// ----------------------------------------------------------------------------
interface mlr_cmd_if
    import mlr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic [0:0]                   op;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;

    modport source (
        output valid, op, start_x, start_y, end_x, end_y,
        input  ready
    );

    modport sink (
        input  valid, op, start_x, start_y, end_x, end_y,
        output ready
    );
endinterface

### rtl/core/mlr_pix_if.sv
// ----------------------------------------------------------------------------
// mlr_pix_if
// Pixel channel: one rasterized pixel with a last-of-line flag.
// ----------------------------------------------------------------------------
interface mlr_pix_if
    import mlr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic                         last;

    modport source (
        output valid, pixel_x, pixel_y, last,
        input  ready
    );

    modport sink (
        input  valid, pixel_x, pixel_y, last,
        output ready
    );
endinterface

### rtl/core/mlr_setup.sv
// ----------------------------------------------------------------------------
// mlr_setup
// Line setup: octant classification, mirroring into octant 0, decision terms.
// ----------------------------------------------------------------------------
module mlr_setup
    import mlr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    output t_octant                      o_octant,
    output logic signed [COORD_BITS:0]   o_walk_x,
    output logic signed [COORD_BITS:0]   o_walk_y,
    output logic signed [COORD_BITS:0]   o_walk_end_x,
    output logic signed [COORD_BITS+2:0] o_decision,
    output logic signed [COORD_BITS+2:0] o_step_east,
    output logic signed [COORD_BITS+2:0] o_step_diag
);
    localparam int PW = COORD_BITS + 1;   // mirrored position width
    localparam int DW = COORD_BITS + 3;   // decision term width

    logic signed [PW-1:0] x0, y0, x1, y1;
    logic signed [PW-1:0] dx, dy;
    logic        [PW-1:0] abs_dx, abs_dy;
    logic                 x_major;
    t_octant              oct;
    logic signed [PW-1:0] a0, b0, a1, b1;
    logic signed [DW-1:0] dx_m, dy_m;

    assign x0 = PW'(i_start_x);
    assign y0 = PW'(i_start_y);
    assign x1 = PW'(i_end_x);
    assign y1 = PW'(i_end_y);

    assign dx     = x1 - x0;
    assign dy     = y1 - y0;
    assign abs_dx = dx[PW-1] ? PW'(-dx) : PW'(dx);
    assign abs_dy = dy[PW-1] ? PW'(-dy) : PW'(dy);
    assign x_major = (abs_dx >= abs_dy);

    always_comb begin
        case ({x_major, dx[PW-1], dy[PW-1]})
            3'b100:  oct = OCT_X_PP;
            3'b101:  oct = OCT_X_PN;
            3'b110:  oct = OCT_X_NP;
            3'b111:  oct = OCT_X_NN;
            3'b000:  oct = OCT_Y_PP;
            3'b001:  oct = OCT_Y_PN;
            3'b010:  oct = OCT_Y_NP;
            default: oct = OCT_Y_NN;
        endcase
    end

    // mirror both endpoints into octant 0
    always_comb begin
        unique case (oct)
            OCT_X_PP: begin a0 = x0;  b0 = y0;  a1 = x1;  b1 = y1;  end
            OCT_Y_PP: begin a0 = y0;  b0 = x0;  a1 = y1;  b1 = x1;  end
            OCT_Y_NP: begin a0 = y0;  b0 = -x0; a1 = y1;  b1 = -x1; end
            OCT_X_NP: begin a0 = -x0; b0 = y0;  a1 = -x1; b1 = y1;  end
            OCT_X_NN: begin a0 = -x0; b0 = -y0; a1 = -x1; b1 = -y1; end
            OCT_Y_NN: begin a0 = -y0; b0 = -x0; a1 = -y1; b1 = -x1; end
            OCT_Y_PN: begin a0 = -y0; b0 = x0;  a1 = -y1; b1 = x1;  end
            OCT_X_PN: begin a0 = x0;  b0 = -y0; a1 = x1;  b1 = -y1; end
        endcase
    end

    assign dx_m = DW'(a1) - DW'(a0);
    assign dy_m = DW'(b1) - DW'(b0);

    assign o_octant     = oct;
    assign o_walk_x     = a0;
    assign o_walk_y     = b0;
    assign o_walk_end_x = a1;
    assign o_step_east  = dy_m <<< 1;
    assign o_step_diag  = (dy_m - dx_m) <<< 1;
    assign o_decision   = (dy_m <<< 1) - dx_m;
endmodule

### rtl/core/midpoint_line_rasterizer.sv
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer
// Midpoint line walker over all eight octants, one pixel per step command.
// ----------------------------------------------------------------------------
//  channel   dir  modport   payload
//  i_cmd     in   sink      op, start_x, start_y, end_x, end_y
//  o_pix     out  source    pixel_x, pixel_y, last
//
//  A command is registered on transfer and executed once the pixel register
//  is free or being read; a step result lands in the pixel register, and one
//  command is taken every cycle while o_pix accepts pixels. The pixel register
//  is the only point that stalls: while it holds an untaken pixel, the
//  command register waits and i_cmd.ready follows o_pix.ready. Reset clears
//  both valid flags and the busy flag, so the block comes up idle.
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer
    import mlr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mlr_cmd_if.sink   i_cmd,
    mlr_pix_if.source o_pix
);
    localparam int PW = COORD_BITS + 1;
    localparam int DW = COORD_BITS + 3;

    // command register
    logic                         r_in_valid;
    t_op                          r_in_op;
    logic signed [COORD_BITS-1:0] r_in_start_x, r_in_start_y, r_in_end_x, r_in_end_y;

    // walk state
    logic                 r_busy;
    t_octant              r_octant;
    logic signed [PW-1:0] r_walk_x, r_walk_y, r_walk_end_x;
    logic signed [DW-1:0] r_decision, r_step_east, r_step_diag;

    // pixel register
    logic                         r_out_valid;
    logic signed [COORD_BITS-1:0] r_out_x, r_out_y;
    logic                         r_out_last;

    t_octant              s_octant;
    logic signed [PW-1:0] s_walk_x, s_walk_y, s_walk_end_x;
    logic signed [DW-1:0] s_decision, s_step_east, s_step_diag;

    logic                 w_go;
    logic                 w_emit;
    logic                 w_fin;
    logic signed [PW-1:0] w_ux, w_uy;

    mlr_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .i_start_x    (r_in_start_x),
        .i_start_y    (r_in_start_y),
        .i_end_x      (r_in_end_x),
        .i_end_y      (r_in_end_y),
        .o_octant     (s_octant),
        .o_walk_x     (s_walk_x),
        .o_walk_y     (s_walk_y),
        .o_walk_end_x (s_walk_end_x),
        .o_decision   (s_decision),
        .o_step_east  (s_step_east),
        .o_step_diag  (s_step_diag)
    );

    assign w_go        = r_in_valid && (!r_out_valid || o_pix.ready);
    assign i_cmd.ready = !r_in_valid || w_go;
    assign w_fin       = (r_walk_x >= r_walk_end_x);
    // a step on a live line fills the pixel register
    assign w_emit      = w_go && (r_in_op == OP_STEP) && r_busy;

    // map the walk position back to the original orientation
    always_comb begin
        unique case (r_octant)
            OCT_X_PP: begin w_ux = r_walk_x;  w_uy = r_walk_y;  end
            OCT_Y_PP: begin w_ux = r_walk_y;  w_uy = r_walk_x;  end
            OCT_Y_NP: begin w_ux = -r_walk_y; w_uy = r_walk_x;  end
            OCT_X_NP: begin w_ux = -r_walk_x; w_uy = r_walk_y;  end
            OCT_X_NN: begin w_ux = -r_walk_x; w_uy = -r_walk_y; end
            OCT_Y_NN: begin w_ux = -r_walk_y; w_uy = -r_walk_x; end
            OCT_Y_PN: begin w_ux = r_walk_y;  w_uy = -r_walk_x; end
            OCT_X_PN: begin w_ux = r_walk_x;  w_uy = -r_walk_y; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_busy      <= 1'b0;
        end else begin
            if (i_cmd.valid && i_cmd.ready) begin
                r_in_valid   <= 1'b1;
                r_in_op      <= t_op'(i_cmd.op);
                r_in_start_x <= i_cmd.start_x;
                r_in_start_y <= i_cmd.start_y;
                r_in_end_x   <= i_cmd.end_x;
                r_in_end_y   <= i_cmd.end_y;
            end else if (w_go) begin
                r_in_valid <= 1'b0;
            end

            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_pix.ready) begin
                r_out_valid <= 1'b0;
            end

            if (w_go) begin
                if (r_in_op == OP_LOAD) begin
                    // a load drops any line in progress
                    r_busy       <= 1'b1;
                    r_octant     <= s_octant;
                    r_walk_x     <= s_walk_x;
                    r_walk_y     <= s_walk_y;
                    r_walk_end_x <= s_walk_end_x;
                    r_decision   <= s_decision;
                    r_step_east  <= s_step_east;
                    r_step_diag  <= s_step_diag;
                end else if (r_busy) begin
                    r_out_x     <= w_ux[COORD_BITS-1:0];
                    r_out_y     <= w_uy[COORD_BITS-1:0];
                    r_out_last  <= w_fin;
                    // tie goes diagonal
                    if (r_decision[DW-1]) begin
                        r_decision <= r_decision + r_step_east;
                    end else begin
                        r_walk_y   <= r_walk_y + PW'(1);
                        r_decision <= r_decision + r_step_diag;
                    end
                    r_walk_x <= r_walk_x + PW'(1);
                    if (w_fin) begin
                        r_busy <= 1'b0;
                    end
                end
            end
        end
    end

    assign o_pix.valid   = r_out_valid;
    assign o_pix.pixel_x = r_out_x;
    assign o_pix.pixel_y = r_out_y;
    assign o_pix.last    = r_out_last;
endmodule
